// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file of the octave band equalizer.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define OBA_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("equalizer check failed");

// next-cycle implication
`define OBA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("equalizer check failed");

`endif

// ----- src/oba_pkg.sv -----
// Shared constants, types and build-time coefficient tables of the equalizer.
// No dependencies; every design module imports it.
package oba_pkg;

   localparam int BANDS       = 9;
   localparam int SAMPLE_RATE = 48000;
   localparam int BASE_FREQ   = 16;

   localparam int BAND_W      = (BANDS > 1) ? $clog2(BANDS) : 1;
   localparam int SAMPLE_W    = 16;
   localparam int SMP_W       = SAMPLE_W + 7;
   localparam int COEF_W      = 24;
   localparam int STATE_W     = 32;
   localparam int GAIN_W      = 8;
   localparam int CSR_W       = 32;
   localparam int CSR_IDX_W   = 2;
   localparam int FRAC_W      = 22;
   localparam int MUL_W       = COEF_W + STATE_W;
   localparam int SUM_W       = MUL_W + 1;
   localparam int FS_W        = SUM_W - FRAC_W;
   localparam int DIFF_W      = FS_W + 1;
   localparam int X_W         = FS_W + 1;
   localparam int D_W         = X_W;
   localparam int PROD_W      = D_W + GAIN_W + 1;
   localparam int ACC_W       = PROD_W + BAND_W + 1;
   localparam int SCALE_SHIFT = 15;
   localparam int OUT_SHIFT   = 29;
   localparam int SCALED_W    = ACC_W + SCALE_SHIFT + 1;
   localparam int Y_W         = SCALED_W - OUT_SHIFT;

   localparam logic [CSR_W-1:0]  GAIN_LO_RST   = 32'h0000_0000;
   localparam logic [CSR_W-1:0]  GAIN_HI_RST   = 32'h8000_0080;
   localparam logic [GAIN_W-1:0] GAIN_NINE_RST = 8'h00;

   typedef logic signed [COEF_W-1:0]  coef_type;
   typedef coef_type                  coef_tab_type [BANDS];
   typedef logic signed [STATE_W-1:0] state_type;
   typedef logic signed [MUL_W-1:0]   mul_type;

   localparam state_type STATE_MAX = {1'b0, {(STATE_W-1){1'b1}}};
   localparam state_type STATE_MIN = {1'b1, {(STATE_W-1){1'b0}}};
   localparam logic signed [SAMPLE_W-1:0] OUT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] OUT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_LO   = 2'd0,
      CSR_GAIN_HI   = 2'd1,
      CSR_GAIN_NINE = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_ISSUE,
      SEQ_DRAIN
   } seq_state_type;

   typedef struct packed {
      logic              valid;
      logic              first;
      logic              last;
      logic [BAND_W-1:0] band;
   } issue_type;

   typedef struct packed {
      logic              we;
      logic [BAND_W-1:0] addr;
      state_type         d1;
      state_type         d2;
   } wr_type;

   typedef struct packed {
      logic signed [63:0] sn;
      logic signed [63:0] cs;
   } trig_type;

   localparam logic signed [63:0] ONE_Q30     = 64'sd1073741824;
   localparam logic [63:0]        HALF_PI_Q30 = 64'd1686629713;
   localparam logic signed [63:0] COEF_MAX    = 64'sd8388607;
   localparam logic signed [63:0] COEF_MIN    = -64'sd8388608;
   localparam logic signed [63:0] COEF_ONE    = 64'sd4194304;

   // Build-time only: restoring division, quotient or remainder.
   function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den,
                                        input logic want_rem);
      logic [63:0] q;
      logic [63:0] rem;
      q   = '0;
      rem = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[62:0], num[i]};
         if (rem >= den) begin
            rem  = rem - den;
            q[i] = 1'b1;
         end
      end
      return want_rem ? rem : q;
   endfunction

   // Build-time only: signed division truncating toward zero.
   function automatic logic signed [63:0] sdiv(input logic signed [63:0] num,
                                                input logic signed [63:0] den);
      logic [63:0] an;
      logic [63:0] ad;
      logic [63:0] q;
      an = num[63] ? 64'(-num) : 64'(num);
      ad = den[63] ? 64'(-den) : 64'(den);
      q  = udiv(an, ad, 1'b0);
      return (num[63] ^ den[63]) ? -$signed(q) : $signed(q);
   endfunction

   function automatic logic signed [63:0] sat_coef(input logic signed [63:0] v);
      logic signed [63:0] res;
      res = v;
      if (v > COEF_MAX) begin
         res = COEF_MAX;
      end else if (v < COEF_MIN) begin
         res = COEF_MIN;
      end
      return res;
   endfunction

   // Q30 sine and cosine of 2*pi*freq/SAMPLE_RATE.
   function automatic trig_type trig_q30(input logic [63:0] freq);
      logic [63:0]        red;
      logic [63:0]        ph;
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        ts;
      logic [63:0]        tc;
      logic signed [63:0] s;
      logic signed [63:0] c;
      logic [1:0]         quad;
      trig_type           t;
      red  = udiv(freq, 64'(SAMPLE_RATE), 1'b1);
      ph   = udiv(red << 32, 64'(SAMPLE_RATE), 1'b0);
      quad = ph[31:30];
      x    = ((ph & 64'h3FFF_FFFF) * HALF_PI_Q30) >> 30;
      x2   = (x * x) >> 30;
      ts   = x;
      tc   = 64'(ONE_Q30);
      s    = $signed(x);
      c    = ONE_Q30;
      for (int k = 1; k <= 6; k++) begin
         ts = udiv((ts * x2) >> 30, 64'((2 * k) * (2 * k + 1)), 1'b0);
         tc = udiv((tc * x2) >> 30, 64'((2 * k - 1) * (2 * k)), 1'b0);
         if ((k & 1) == 1) begin
            s = s - $signed(ts);
            c = c - $signed(tc);
         end else begin
            s = s + $signed(ts);
            c = c + $signed(tc);
         end
      end
      case (quad)
         2'd0: begin
            t.sn = s;
            t.cs = c;
         end
         2'd1: begin
            t.sn = c;
            t.cs = -s;
         end
         2'd2: begin
            t.sn = -s;
            t.cs = -c;
         end
         default: begin
            t.sn = -c;
            t.cs = s;
         end
      endcase
      return t;
   endfunction

   function automatic coef_tab_type build_coefs(input logic want_a);
      coef_tab_type       tab;
      trig_type           tb;
      trig_type           tcn;
      logic signed [63:0] num;
      logic signed [63:0] den;
      logic signed [63:0] r;
      logic signed [63:0] a;
      for (int b = 0; b < BANDS; b++) begin
         tb  = trig_q30(64'(BASE_FREQ) << b);
         tcn = trig_q30(64'(BASE_FREQ) << (b + 1));
         num = ONE_Q30 + tb.cs - tb.sn;
         den = ONE_Q30 + tb.cs + tb.sn;
         if (den < 64'sd1) begin
            den = 64'sd1;
         end
         r = sat_coef(sdiv(num * COEF_ONE, den));
         a = sat_coef(-sdiv((COEF_ONE + r) * tcn.cs, ONE_Q30));
         tab[b] = want_a ? COEF_W'(a) : COEF_W'(r);
      end
      return tab;
   endfunction

   localparam coef_tab_type COEF_R = build_coefs(1'b0);
   localparam coef_tab_type COEF_A = build_coefs(1'b1);

endpackage

// ----- src/oba_delay_mem.sv -----
// Per-band allpass delay memory: one write port, one registered read port.
// Entries carry valid bits so unwritten bands read as zero. Uses oba_pkg.
module oba_delay_mem
   import oba_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [BAND_W-1:0] rd_addr,
   input  wr_type            wr,
   output state_type         rd_d1,
   output state_type         rd_d2
);

   logic [2*STATE_W-1:0] mem [BANDS];
   logic [BANDS-1:0]     vld_ff;
   logic [BANDS-1:0]     vld_in;
   logic [2*STATE_W-1:0] rdata_ff;
   logic                 rvld_ff;

   always_comb begin
      vld_in = vld_ff;
      if (wr.we) begin
         vld_in[wr.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem[wr.addr] <= {wr.d1, wr.d2};
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
         rvld_ff  <= vld_ff[rd_addr];
      end
   end

   assign rd_d1 = rvld_ff ? rdata_ff[2*STATE_W-1:STATE_W] : '0;
   assign rd_d2 = rvld_ff ? rdata_ff[STATE_W-1:0] : '0;

endmodule

// ----- src/oba_band_dp.sv -----
// Band pipeline: allpass update, band-pass split, gain and accumulation.
// Reads and writes the delay memory; uses oba_pkg for formats and coefficients.
module oba_band_dp
   import oba_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  issue_type               issue,
   input  logic signed [SMP_W-1:0] smp,
   input  state_type               rd_d1,
   input  state_type               rd_d2,
   input  logic [CSR_W-1:0]        gain_lo,
   input  logic [CSR_W-1:0]        gain_hi,
   input  logic [GAIN_W-1:0]       gain_nine,
   output wr_type                  wr,
   output logic                    acc_done,
   output logic signed [ACC_W-1:0] acc_sum
);

   issue_type t1_ff, t2_ff, t3_ff, t4_ff, t5_ff, t6_ff, t7_ff, t8_ff;
   logic      acc_done_ff;

   coef_type r1_ff, a1_ff, r2_ff, r3_ff, r4_ff;
   mul_type  mau2_ff, mru2_ff, mau3_ff, mau4_ff, mau5_ff, mru5_ff;
   mul_type  mau_in, mru2_in, mru0_in;
   state_type u1_2_ff, u2_2_ff, u1_3_ff, u2_3_ff;
   state_type u0_4_ff, u1_4_ff, u2_4_ff, u2_5_ff, u2_6_ff;
   state_type u0_in;

   logic signed [SUM_W-1:0]  psum;
   logic signed [SUM_W-1:0]  qsum;
   logic signed [FS_W-1:0]   fs3_ff, fs_in;
   logic signed [FS_W-1:0]   q6_ff, q_in;
   logic signed [DIFF_W-1:0] diff;
   logic signed [X_W-1:0]    x;
   logic signed [X_W:0]      e;
   logic signed [D_W-1:0]    d7_ff, d_in;
   logic [GAIN_W-1:0]        gain7_ff, gain_in;
   logic [3:0]               gsel;
   logic [4:0]               gbase;
   logic signed [PROD_W-1:0] prod8_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_ff       <= '0;
         t2_ff       <= '0;
         t3_ff       <= '0;
         t4_ff       <= '0;
         t5_ff       <= '0;
         t6_ff       <= '0;
         t7_ff       <= '0;
         t8_ff       <= '0;
         acc_done_ff <= 1'b0;
      end else begin
         t1_ff       <= issue;
         t2_ff       <= t1_ff;
         t3_ff       <= t2_ff;
         t4_ff       <= t3_ff;
         t5_ff       <= t4_ff;
         t6_ff       <= t5_ff;
         t7_ff       <= t6_ff;
         t8_ff       <= t7_ff;
         acc_done_ff <= t8_ff.valid && t8_ff.last;
      end
   end

   always_comb begin
      mau_in  = mul_type'(a1_ff) * mul_type'(rd_d1);
      mru2_in = mul_type'(r1_ff) * mul_type'(rd_d2);

      psum  = SUM_W'(mau2_ff) + SUM_W'(mru2_ff);
      fs_in = psum[SUM_W-1:FRAC_W];

      diff = DIFF_W'(smp) - DIFF_W'(fs3_ff);
      if (diff[DIFF_W-1:STATE_W-1] == '0 || diff[DIFF_W-1:STATE_W-1] == '1) begin
         u0_in = diff[STATE_W-1:0];
      end else begin
         u0_in = diff[DIFF_W-1] ? STATE_MIN : STATE_MAX;
      end

      mru0_in = mul_type'(r4_ff) * mul_type'(u0_4_ff);

      qsum = SUM_W'(mru5_ff) + SUM_W'(mau5_ff);
      q_in = qsum[SUM_W-1:FRAC_W];

      x    = X_W'(q6_ff) + X_W'(u2_6_ff);
      e    = (X_W + 1)'(smp) - (X_W + 1)'(x);
      d_in = e[X_W:1];

      gsel  = 4'(t6_ff.band);
      gbase = {gsel[1:0], 3'b000};
      if (gsel < 4'd4) begin
         gain_in = gain_lo[gbase +: GAIN_W];
      end else if (gsel < 4'd8) begin
         gain_in = gain_hi[gbase +: GAIN_W];
      end else begin
         gain_in = gain_nine;
      end

      prod_in = PROD_W'(d7_ff) * PROD_W'($signed({1'b0, gain7_ff}));

      acc_in = t8_ff.first ? ACC_W'(prod8_ff) : acc_ff + ACC_W'(prod8_ff);
   end

   always_ff @(posedge clock) begin
      r1_ff    <= COEF_R[issue.band];
      a1_ff    <= COEF_A[issue.band];

      mau2_ff  <= mau_in;
      mru2_ff  <= mru2_in;
      u1_2_ff  <= rd_d1;
      u2_2_ff  <= rd_d2;
      r2_ff    <= r1_ff;

      fs3_ff   <= fs_in;
      mau3_ff  <= mau2_ff;
      u1_3_ff  <= u1_2_ff;
      u2_3_ff  <= u2_2_ff;
      r3_ff    <= r2_ff;

      u0_4_ff  <= u0_in;
      mau4_ff  <= mau3_ff;
      u1_4_ff  <= u1_3_ff;
      u2_4_ff  <= u2_3_ff;
      r4_ff    <= r3_ff;

      mru5_ff  <= mru0_in;
      mau5_ff  <= mau4_ff;
      u2_5_ff  <= u2_4_ff;

      q6_ff    <= q_in;
      u2_6_ff  <= u2_5_ff;

      d7_ff    <= d_in;
      gain7_ff <= gain_in;

      prod8_ff <= prod_in;

      if (t8_ff.valid) begin
         acc_ff <= acc_in;
      end
   end

   assign wr = '{we: t4_ff.valid, addr: t4_ff.band, d1: u0_4_ff, d2: u1_4_ff};

   assign acc_done = acc_done_ff;
   assign acc_sum  = acc_ff;

endmodule

// ----- src/oba_out_stage.sv -----
// Output scaling by 32767/2^29, truncation toward zero, saturation and result register.
// Fed by oba_band_dp; uses oba_pkg.
module oba_out_stage
   import oba_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       acc_done,
   input  logic signed [ACC_W-1:0]    acc_sum,
   input  logic                       rsp_stall,
   output logic                       rsp_valid,
   output logic signed [SAMPLE_W-1:0] rsp_sample_out,
   output logic                       rsp_clipped,
   output logic                       load
);

   logic                       fin_ff;
   logic                       rsp_valid_ff;
   logic signed [SCALED_W-1:0] scaled_ff;
   logic signed [SCALED_W-1:0] scaled_in;
   logic signed [SCALED_W-1:0] adj;
   logic signed [Y_W-1:0]      y;
   logic                       in_range;
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;
   logic                       clip_ff;

   assign load = fin_ff && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      scaled_in = (SCALED_W'(acc_sum) <<< SCALE_SHIFT) - SCALED_W'(acc_sum);
      adj = scaled_ff[SCALED_W-1] ? scaled_ff + SCALED_W'({OUT_SHIFT{1'b1}}) : scaled_ff;
      y   = adj[SCALED_W-1:OUT_SHIFT];
      in_range = (y[Y_W-1:SAMPLE_W-1] == '0) || (y[Y_W-1:SAMPLE_W-1] == '1);
      if (in_range) begin
         sample_in = y[SAMPLE_W-1:0];
      end else begin
         sample_in = y[Y_W-1] ? OUT_MIN : OUT_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (acc_done) begin
            fin_ff <= 1'b1;
         end else if (load) begin
            fin_ff <= 1'b0;
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (acc_done) begin
         scaled_ff <= scaled_in;
      end
      if (load) begin
         sample_ff <= sample_in;
         clip_ff   <= !in_range;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = sample_ff;
   assign rsp_clipped    = clip_ff;

endmodule

// ----- src/octave_band_allpass_equalizer.sv -----
// Octave band allpass equalizer: nine second-order allpass bands, gain-weighted band-pass sum.
// Each accepted input beat walks the nine bands, and its scaled sum is registered as the result.
// Throughput: nine bands one per cycle; new input waits until the last result is loaded, and a
// result beat still stalled when the next one is ready holds off further input.
// Reset: synchronous; gains return to their defaults, delay memory valid bits clear so all
// delays read as zero at once, no clearing pass. Uses oba_pkg and the oba_* submodules.
module octave_band_allpass_equalizer
   import oba_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_sample_in,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_sample_out,
   output logic                       rsp_clipped,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_W-1:0]           csr_wdata
);

   seq_state_type           state_ff, state_in;
   logic [BAND_W-1:0]       band_ff, band_in;
   issue_type               issue;
   logic signed [SMP_W-1:0] smp_ff;
   logic [CSR_W-1:0]        gain_lo_ff;
   logic [CSR_W-1:0]        gain_hi_ff;
   logic [GAIN_W-1:0]       gain_nine_ff;
   state_type               rd_d1, rd_d2;
   wr_type                  wr;
   logic                    acc_done;
   logic signed [ACC_W-1:0] acc_sum;
   logic                    out_load;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != SEQ_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_lo_ff   <= GAIN_LO_RST;
         gain_hi_ff   <= GAIN_HI_RST;
         gain_nine_ff <= GAIN_NINE_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_GAIN_LO:   gain_lo_ff   <= csr_wdata;
            CSR_GAIN_HI:   gain_hi_ff   <= csr_wdata;
            CSR_GAIN_NINE: gain_nine_ff <= csr_wdata[GAIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         band_ff  <= '0;
      end else begin
         state_ff <= state_in;
         band_ff  <= band_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      band_in  = band_ff;
      issue    = '0;
      unique case (state_ff)
         SEQ_IDLE: begin
            if (req_valid) begin
               state_in = SEQ_ISSUE;
               band_in  = '0;
            end
         end
         SEQ_ISSUE: begin
            issue.valid = 1'b1;
            issue.band  = band_ff;
            issue.first = (band_ff == '0);
            issue.last  = (band_ff == BAND_W'(BANDS - 1));
            if (issue.last) begin
               state_in = SEQ_DRAIN;
            end else begin
               band_in = band_ff + BAND_W'(1);
            end
         end
         SEQ_DRAIN: begin
            if (out_load) begin
               state_in = SEQ_IDLE;
            end
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   // hold the scaled sample for the whole band walk
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         smp_ff <= {req_sample_in, 7'b000_0000};
      end
   end

   oba_delay_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (issue.valid),
      .rd_addr (issue.band),
      .wr      (wr),
      .rd_d1   (rd_d1),
      .rd_d2   (rd_d2)
   );

   oba_band_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .issue     (issue),
      .smp       (smp_ff),
      .rd_d1     (rd_d1),
      .rd_d2     (rd_d2),
      .gain_lo   (gain_lo_ff),
      .gain_hi   (gain_hi_ff),
      .gain_nine (gain_nine_ff),
      .wr        (wr),
      .acc_done  (acc_done),
      .acc_sum   (acc_sum)
   );

   oba_out_stage u_out (
      .clock          (clock),
      .reset          (reset),
      .acc_done       (acc_done),
      .acc_sum        (acc_sum),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_sample_out (rsp_sample_out),
      .rsp_clipped    (rsp_clipped),
      .load           (out_load)
   );

endmodule

// ----- src/oba_checker.sv -----
// Port-level checks of the octave band equalizer, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module oba_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_sample_out,
   input logic        rsp_clipped
);

   `OBA_ASSERT_NEXT(a_one_item_in_flight, clock, reset, req_valid && !req_stall, req_stall)
   `OBA_ASSERT_NOW(a_clip_at_rail, clock, reset, rsp_valid && rsp_clipped, rsp_sample_out == 16'h7fff || rsp_sample_out == 16'h8000)
   `OBA_ASSERT_NOW(a_result_after_item, clock, reset, $rose(rsp_valid), $past(req_stall))
   `OBA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_sample_out) && $stable(rsp_clipped))

endmodule

bind octave_band_allpass_equalizer oba_checker u_oba_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_sample_out (rsp_sample_out),
   .rsp_clipped    (rsp_clipped)
);
